// ----- rtl/dhg_pkg.sv -----
package dhg_pkg;

    // Fixed field and counter widths.
    localparam int OP_W    = 2;
    localparam int DEPTH_W = 16;
    localparam int CNT_W   = 20;
    localparam int GRAY_W  = 8;

    // Default number of histogram bins.
    localparam int DEPTH_BINS_DEF = 16384;

    // Opcodes of an input item.
    localparam logic [OP_W-1:0] OP_COUNT  = 2'd0;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
    localparam logic [OP_W-1:0] OP_MAP    = 2'd2;

    // Request to the shift-subtract divider.
    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  rem;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

    // Response from the divider.
    typedef struct packed {
        logic              done;
        logic [GRAY_W-1:0] quot;
    } div_rsp_t;

endpackage

// ----- rtl/dhg_ram.sv -----
module dhg_ram #(
    parameter int DEPTH  = dhg_pkg::DEPTH_BINS_DEF,
    parameter int WIDTH  = dhg_pkg::CNT_W,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/dhg_divider.sv -----
module dhg_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  dhg_pkg::div_req_t req,
    output dhg_pkg::div_rsp_t rsp
);

    localparam int STEP_W = $clog2(dhg_pkg::GRAY_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(dhg_pkg::GRAY_W - 1);

    logic [dhg_pkg::CNT_W-1:0]  rem_reg;
    logic [dhg_pkg::CNT_W-1:0]  div_reg;
    logic [dhg_pkg::GRAY_W-1:0] quot_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [dhg_pkg::CNT_W:0] dbl;
    logic [dhg_pkg::CNT_W:0] diff;
    logic                    ge;

    // One quotient bit per cycle: the remainder stays below the divisor.
    always_comb begin
        dbl  = {rem_reg, 1'b0};
        ge   = (dbl >= {1'b0, div_reg});
        diff = dbl - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= req.rem;
                div_reg  <= req.divisor;
                quot_reg <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? diff[dhg_pkg::CNT_W-1:0] : dbl[dhg_pkg::CNT_W-1:0];
                quot_reg <= {quot_reg[dhg_pkg::GRAY_W-2:0], ge};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ----- rtl/depth_histogram_grayscale_unit.sv -----
// Channel   Direction  Handshake          Payload
// s_ (in)   input      s_valid / s_ready  s_opcode[1:0], s_depth[15:0]
// m_ (out)  output     m_valid / m_ready  m_gray[7:0], m_has_depth, m_out_of_range
//
// A count item reads and then writes its bin, a map item reads the table before it emits,
// and an item that gives a result at once goes straight to the output.
// A finish item walks all DEPTH_BINS bins; a bin whose grey level is known directly
// is read, summed and written, and any other bin also waits on the 8-step divider.
// After reset a clearing pass over all DEPTH_BINS bins zeroes both stores; s_ready is low.
// A new result that finds the output register still full holds until m_ready frees it.
module depth_histogram_grayscale_unit #(
    parameter int DEPTH_BINS = dhg_pkg::DEPTH_BINS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dhg_pkg::OP_W-1:0]     s_opcode,
    input  logic [dhg_pkg::DEPTH_W-1:0]  s_depth,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [dhg_pkg::GRAY_W-1:0]   m_gray,
    output logic                         m_has_depth,
    output logic                         m_out_of_range
);

    localparam int ADDR_W = $clog2(DEPTH_BINS);
    localparam logic [ADDR_W-1:0] BIN_LAST = ADDR_W'(DEPTH_BINS - 1);
    localparam logic [dhg_pkg::DEPTH_W:0] BINS_L = (dhg_pkg::DEPTH_W + 1)'(DEPTH_BINS);
    localparam logic [dhg_pkg::CNT_W-1:0] CNT_MAX = '1;
    // The running sum is clamped here; any value at or above it compares as >= n.
    localparam logic [dhg_pkg::CNT_W:0] SUM_LIM = {1'b1, {dhg_pkg::CNT_W{1'b0}}};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_FIN_RD,
        ST_FIN_ACC,
        ST_FIN_DIV,
        ST_FIN_WR,
        ST_MAP_RD,
        ST_MAP_DATA,
        ST_EMIT
    } state_t;

    state_t                      state_reg;
    logic [ADDR_W-1:0]           addr_reg;      // depth of the item, or the bin being walked
    logic [dhg_pkg::CNT_W-1:0]   valid_pts_reg;
    logic [dhg_pkg::CNT_W:0]     csum_reg;
    logic [dhg_pkg::GRAY_W-1:0]  gval_reg;
    logic [dhg_pkg::GRAY_W-1:0]  res_gray_reg;
    logic                        res_has_reg;
    logic                        res_oor_reg;
    logic                        m_valid_reg;
    logic [dhg_pkg::GRAY_W-1:0]  m_gray_reg;
    logic                        m_has_reg;
    logic                        m_oor_reg;

    logic                        cnt_we;
    logic [ADDR_W-1:0]           cnt_waddr;
    logic [dhg_pkg::CNT_W-1:0]   cnt_wdata;
    logic [dhg_pkg::CNT_W-1:0]   cnt_rdata;
    logic                        gray_we;
    logic [ADDR_W-1:0]           gray_waddr;
    logic [dhg_pkg::GRAY_W-1:0]  gray_wdata;
    logic [dhg_pkg::GRAY_W-1:0]  gray_rdata;

    logic                        accept;
    logic                        depth_zero;
    logic                        depth_oor;
    logic [dhg_pkg::CNT_W+1:0]   sum_wide;
    logic [dhg_pkg::CNT_W:0]     csum_sat;
    logic                        gray_zero;
    logic                        gray_full;
    dhg_pkg::div_req_t           div_req;
    dhg_pkg::div_rsp_t           div_rsp;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign depth_zero = (s_depth == '0);
    assign depth_oor  = ({1'b0, s_depth} >= BINS_L);

    // Running sum over the bins, clamped so that it never wraps.
    always_comb begin
        sum_wide = {1'b0, csum_reg} + (dhg_pkg::CNT_W + 2)'(cnt_rdata);
        if (sum_wide >= {1'b0, SUM_LIM}) begin
            csum_sat = SUM_LIM;
        end else begin
            csum_sat = sum_wide[dhg_pkg::CNT_W:0];
        end
        // No points, or the sum has reached the count: the grey level is zero.
        gray_zero = (valid_pts_reg == '0) || (csum_sat >= {1'b0, valid_pts_reg});
        // Empty running sum: the formula gives 256, which saturates to 255.
        gray_full = (csum_sat == '0);
    end

    assign div_req.start   = (state_reg == ST_FIN_ACC) && !gray_zero && !gray_full;
    assign div_req.rem     = valid_pts_reg - csum_sat[dhg_pkg::CNT_W-1:0];
    assign div_req.divisor = valid_pts_reg;

    // Write ports of the two stores. The clearing pass uses addr_reg as its index.
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = addr_reg;
        cnt_wdata = '0;
        gray_we   = 1'b0;
        gray_waddr = addr_reg;
        gray_wdata = gval_reg;
        case (state_reg)
            ST_CLEAR: begin
                cnt_we     = 1'b1;
                gray_we    = 1'b1;
                gray_wdata = '0;
            end
            ST_CNT_WR: begin
                cnt_we    = 1'b1;
                cnt_wdata = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
            end
            ST_FIN_ACC: begin
                // The bin is cleared as soon as it has been summed.
                cnt_we = 1'b1;
            end
            ST_FIN_WR: begin
                gray_we = 1'b1;
            end
            default: begin
                cnt_we  = 1'b0;
                gray_we = 1'b0;
            end
        endcase
    end

    dhg_ram #(
        .DEPTH (DEPTH_BINS),
        .WIDTH (dhg_pkg::CNT_W),
        .ADDR_W(ADDR_W)
    ) u_cnt_ram (
        .aclk (aclk),
        .we   (cnt_we),
        .waddr(cnt_waddr),
        .wdata(cnt_wdata),
        .raddr(addr_reg),
        .rdata(cnt_rdata)
    );

    dhg_ram #(
        .DEPTH (DEPTH_BINS),
        .WIDTH (dhg_pkg::GRAY_W),
        .ADDR_W(ADDR_W)
    ) u_gray_ram (
        .aclk (aclk),
        .we   (gray_we),
        .waddr(gray_waddr),
        .wdata(gray_wdata),
        .raddr(addr_reg),
        .rdata(gray_rdata)
    );

    dhg_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // Sequencer together with the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            valid_pts_reg <= '0;
            csum_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // In ST_EMIT the output register is reloaded below instead.
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (addr_reg == BIN_LAST) begin
                        addr_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        addr_reg     <= (s_opcode == dhg_pkg::OP_FINISH) ? '0
                                                                         : s_depth[ADDR_W-1:0];
                        // A result with depth is present; only a zero depth clears both flags.
                        res_gray_reg <= '0;
                        res_has_reg  <= !depth_zero;
                        res_oor_reg  <= !depth_zero;
                        case (s_opcode)
                            dhg_pkg::OP_COUNT: begin
                                if (depth_zero) begin
                                    state_reg <= ST_IDLE;
                                end else if (depth_oor) begin
                                    state_reg <= ST_EMIT;
                                end else begin
                                    state_reg <= ST_CNT_RD;
                                end
                            end
                            dhg_pkg::OP_FINISH: begin
                                csum_reg  <= '0;
                                state_reg <= ST_FIN_RD;
                            end
                            dhg_pkg::OP_MAP: begin
                                if (depth_zero || depth_oor) begin
                                    state_reg <= ST_EMIT;
                                end else begin
                                    state_reg <= ST_MAP_RD;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_CNT_RD: begin
                    state_reg <= ST_CNT_WR;
                end
                ST_CNT_WR: begin
                    if (valid_pts_reg != CNT_MAX) begin
                        valid_pts_reg <= valid_pts_reg + 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_FIN_RD: begin
                    state_reg <= ST_FIN_ACC;
                end
                ST_FIN_ACC: begin
                    csum_reg <= csum_sat;
                    if (gray_zero) begin
                        gval_reg  <= '0;
                        state_reg <= ST_FIN_WR;
                    end else if (gray_full) begin
                        gval_reg  <= '1;
                        state_reg <= ST_FIN_WR;
                    end else begin
                        state_reg <= ST_FIN_DIV;
                    end
                end
                ST_FIN_DIV: begin
                    if (div_rsp.done) begin
                        gval_reg  <= div_rsp.quot;
                        state_reg <= ST_FIN_WR;
                    end
                end
                ST_FIN_WR: begin
                    if (addr_reg == BIN_LAST) begin
                        addr_reg      <= '0;
                        valid_pts_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end else begin
                        addr_reg  <= addr_reg + 1'b1;
                        state_reg <= ST_FIN_RD;
                    end
                end
                ST_MAP_RD: begin
                    state_reg <= ST_MAP_DATA;
                end
                ST_MAP_DATA: begin
                    res_gray_reg <= gray_rdata;
                    res_oor_reg  <= 1'b0;
                    state_reg    <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_gray_reg  <= res_gray_reg;
                        m_has_reg   <= res_has_reg;
                        m_oor_reg   <= res_oor_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_gray         = m_gray_reg;
    assign m_has_depth    = m_has_reg;
    assign m_out_of_range = m_oor_reg;

endmodule

// ----- rtl/dhg_checker.sv -----
module dhg_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [dhg_pkg::OP_W-1:0]     s_opcode,
    input logic [dhg_pkg::DEPTH_W-1:0]  s_depth,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [dhg_pkg::GRAY_W-1:0]   m_gray,
    input logic                         m_has_depth,
    input logic                         m_out_of_range
);

    // A result that is not taken stays with the same payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_gray) && $stable(m_has_depth)
            && $stable(m_out_of_range))
        else $error("stalled result changed");

    // An ignored out-of-range depth gives grey zero and counts as present.
    a_oor_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_has_depth && (m_gray == '0))
        else $error("out-of-range result malformed");

    // A pixel without depth has grey zero and is not flagged out of range.
    a_nodepth_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_depth |-> (m_gray == '0) && !m_out_of_range)
        else $error("no-depth result malformed");

    // The clearing pass follows reset, so no item is taken just after it.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("ready during clearing pass");

    // An item that does work keeps the block busy in the following cycle.
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && ((s_opcode == dhg_pkg::OP_MAP) || (s_opcode == dhg_pkg::OP_FINISH)
            || ((s_opcode == dhg_pkg::OP_COUNT) && (s_depth != '0)))
            |=> !s_ready)
        else $error("item taken while busy");

endmodule

bind depth_histogram_grayscale_unit dhg_checker u_dhg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_opcode      (s_opcode),
    .s_depth       (s_depth),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_gray        (m_gray),
    .m_has_depth   (m_has_depth),
    .m_out_of_range(m_out_of_range)
);

// ----- tb/sv/depth_histogram_grayscale_unit_test.sv -----
module depth_histogram_grayscale_unit_test;

    // The block is built with its default bin count, and the predictor uses the same.
    localparam int NUM_BINS = dhg_pkg::DEPTH_BINS_DEF;
    localparam logic [dhg_pkg::CNT_W-1:0] CNT_SAT = {dhg_pkg::CNT_W{1'b1}};

    // Opcode 3 has no meaning to the block; it must be dropped without a trace.
    localparam logic [dhg_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Random part size, counted in items sent; with the directed table this
    // gives about 950 items in all.
    localparam int RANDOM_ITEMS = 925;

    // A finish item walks every bin, at worst waiting on the divider for each, without
    // accepting anything. The clearing pass after reset is shorter. The limit leaves a
    // wide margin over both.
    localparam int WATCHDOG_LIMIT = 1000000;

    // The tail wait only needs to catch stray results.
    localparam int TAIL_CYCLES = 64;

    typedef struct {
        logic [dhg_pkg::GRAY_W-1:0] gray;
        logic                       has_depth;
        logic                       out_of_range;
    } pixel_t;

    // How a row of the directed table is checked: against the predictor, as an
    // item that must give no result, or against a value typed into the row.
    typedef enum {ROW_PREDICTED, ROW_SILENT, ROW_TYPED} row_kind_t;

    typedef struct {
        logic [dhg_pkg::OP_W-1:0]    opcode;
        logic [dhg_pkg::DEPTH_W-1:0] depth;
        row_kind_t                   kind;
        pixel_t                      pixel;
    } stim_row_t;

    logic                          aclk;
    logic                          aresetn  = 1'b0;
    logic                          s_valid  = 1'b0;
    logic                          s_ready;
    logic [dhg_pkg::OP_W-1:0]      s_opcode = '0;
    logic [dhg_pkg::DEPTH_W-1:0]   s_depth  = '0;
    logic                          m_valid;
    logic                          m_ready  = 1'b0;
    logic [dhg_pkg::GRAY_W-1:0]    m_gray;
    logic                          m_has_depth;
    logic                          m_out_of_range;

    depth_histogram_grayscale_unit #(
        .DEPTH_BINS(NUM_BINS)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_depth       (s_depth),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_gray        (m_gray),
        .m_has_depth   (m_has_depth),
        .m_out_of_range(m_out_of_range)
    );

    // Shadow copy of the block's state: the bin histogram of the frame being
    // gathered, its valid-point count, and the grey table of the last finish.
    logic [dhg_pkg::CNT_W-1:0]  histogram_bins [NUM_BINS];
    logic [dhg_pkg::CNT_W-1:0]  frame_points;
    logic [dhg_pkg::GRAY_W-1:0] gray_lut [NUM_BINS];

    // Grey pixels still owed by the block, oldest first.
    pixel_t pending_pixels [$];

    stim_row_t directed_rows [$];

    int fail_count     = 0;
    int acted_items    = 0;
    int ignored_items  = 0;
    int sent_items     = 0;
    int checked_pixels = 0;
    int frames_built   = 0;
    int burst_left     = 0;
    int stall_left     = 0;
    int stall_mode     = 0;

    pixel_t seen_pixel;
    pixel_t want_pixel;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Forms the grey table from the running sum over the bins, exactly as
    // floor(256*(n-c)/n) limited to 255, with 0 once c reaches n or when the
    // frame had no valid points. The histogram is then cleared for the next frame.
    function automatic void build_gray_lut();
        longint unsigned total;
        longint unsigned run_sum;
        longint unsigned level;
        total   = frame_points;
        run_sum = 0;
        for (int b = 0; b < NUM_BINS; b++) begin
            run_sum += histogram_bins[b];
            if (total == 0 || run_sum >= total) begin
                level = 0;
            end else begin
                level = (256 * (total - run_sum)) / total;
                if (level > 255) begin
                    level = 255;
                end
            end
            gray_lut[b] = level[dhg_pkg::GRAY_W-1:0];
            histogram_bins[b] = '0;
        end
        frame_points = '0;
        frames_built++;
    endfunction

    // Advances the shadow state by one accepted item and tells whether the
    // item owes a result, and which.
    function automatic void predict_pixel(input logic [dhg_pkg::OP_W-1:0] opcode,
                                          input logic [dhg_pkg::DEPTH_W-1:0] depth,
                                          output bit gives, output pixel_t px);
        gives = 1'b0;
        px    = '{gray: '0, has_depth: 1'b0, out_of_range: 1'b0};
        case (opcode)
            dhg_pkg::OP_COUNT: begin
                if (depth >= NUM_BINS) begin
                    // Too deep for the histogram: flagged, nothing counted.
                    gives = 1'b1;
                    px    = '{gray: '0, has_depth: 1'b1, out_of_range: 1'b1};
                end else if (depth != 0) begin
                    if (histogram_bins[depth] != CNT_SAT) begin
                        histogram_bins[depth]++;
                    end
                    if (frame_points != CNT_SAT) begin
                        frame_points++;
                    end
                end
            end
            dhg_pkg::OP_FINISH: begin
                build_gray_lut();
            end
            dhg_pkg::OP_MAP: begin
                gives = 1'b1;
                if (depth == 0) begin
                    px = '{gray: '0, has_depth: 1'b0, out_of_range: 1'b0};
                end else if (depth >= NUM_BINS) begin
                    px = '{gray: '0, has_depth: 1'b1, out_of_range: 1'b1};
                end else begin
                    px = '{gray: gray_lut[depth], has_depth: 1'b1, out_of_range: 1'b0};
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void add_row(input logic [dhg_pkg::OP_W-1:0] opcode,
                                    input logic [dhg_pkg::DEPTH_W-1:0] depth,
                                    input row_kind_t kind,
                                    input logic [dhg_pkg::GRAY_W-1:0] gray,
                                    input logic has_depth, input logic out_of_range);
        stim_row_t row;
        row.opcode = opcode;
        row.depth  = depth;
        row.kind   = kind;
        row.pixel  = '{gray: gray, has_depth: has_depth, out_of_range: out_of_range};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Offers one item to the block. The sender runs in bursts: when a burst is
    // used up, valid drops for a random gap before the next burst starts. Once
    // valid is up it holds, with the payload, until the block takes the item.
    // On acceptance the predictor is advanced and any result it owes is queued;
    // a typed row queues its own value instead, or nothing when it is silent.
    task automatic send_item(input logic [dhg_pkg::OP_W-1:0] opcode,
                             input logic [dhg_pkg::DEPTH_W-1:0] depth,
                             input row_kind_t kind, input pixel_t typed);
        int     gap;
        bit     gives;
        pixel_t px;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_opcode <= opcode;
        s_depth  <= depth;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);

        sent_items++;
        predict_pixel(opcode, depth, gives, px);
        if (opcode == OP_UNUSED || (opcode == dhg_pkg::OP_COUNT && depth == 0)) begin
            ignored_items++;
        end else begin
            acted_items++;
        end
        case (kind)
            ROW_PREDICTED: if (gives) pending_pixels.insert(pending_pixels.size(), px);
            ROW_TYPED:     pending_pixels.insert(pending_pixels.size(), typed);
            default: begin
            end
        endcase
    endtask

    task automatic send_random(input logic [dhg_pkg::OP_W-1:0] opcode,
                               input logic [dhg_pkg::DEPTH_W-1:0] depth);
        pixel_t unused_px;
        unused_px = '{gray: '0, has_depth: 1'b0, out_of_range: 1'b0};
        send_item(opcode, depth, ROW_PREDICTED, unused_px);
    endtask

    // Now and then an item off the normal frame pattern: ignored items, depths
    // beyond the histogram, and maps of any depth at all.
    task automatic maybe_noise();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: send_random(dhg_pkg::OP_COUNT, '0);
                1: send_random(dhg_pkg::OP_COUNT,
                               dhg_pkg::DEPTH_W'($urandom_range(NUM_BINS, 65535)));
                2: send_random(OP_UNUSED, dhg_pkg::DEPTH_W'($urandom));
                default: send_random(dhg_pkg::OP_MAP, dhg_pkg::DEPTH_W'($urandom));
            endcase
        end
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    // Receiver: m_ready follows a random pattern, redrawn whenever its hold count runs out:
    // always ready, random stalls, or ready only when the hold count is a multiple of four.
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(50, 300);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= (stall_left % 4 == 0);
        endcase
    end

    // Every result taken is compared with the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_pixel = '{gray: m_gray, has_depth: m_has_depth,
                           out_of_range: m_out_of_range};
            if (pending_pixels.size() == 0) begin
                $error("unexpected result: gray %0d, has_depth %0d, out_of_range %0d",
                       seen_pixel.gray, seen_pixel.has_depth, seen_pixel.out_of_range);
                fail_count++;
            end else begin
                want_pixel = pending_pixels.pop_front();
                check_field("gray", want_pixel.gray, seen_pixel.gray);
                check_field("has_depth", want_pixel.has_depth, seen_pixel.has_depth);
                check_field("out_of_range", want_pixel.out_of_range,
                            seen_pixel.out_of_range);
                checked_pixels++;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves an item for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("depth_histogram_grayscale_unit_test: FAIL");
        $finish;
    end

    initial begin : main
        int               target;
        int               lo;
        int               hi;
        int               span;
        int               num_counts;
        int               num_maps;
        int               map_lo;
        stim_row_t        row;

        for (int b = 0; b < NUM_BINS; b++) begin
            histogram_bins[b] = '0;
            gray_lut[b]       = '0;
        end
        frame_points = '0;

        // Directed part. Right after reset the grey table is all zero, and
        // every depth beyond the histogram is flagged in count and map items.
        add_row(dhg_pkg::OP_MAP,    16'd100,   ROW_TYPED,  8'd0, 1'b1, 1'b0);
        add_row(dhg_pkg::OP_MAP,    16'd0,     ROW_TYPED,  8'd0, 1'b0, 1'b0);
        add_row(dhg_pkg::OP_MAP,    16'd16384, ROW_TYPED,  8'd0, 1'b1, 1'b1);
        add_row(dhg_pkg::OP_MAP,    16'hFFFF,  ROW_TYPED,  8'd0, 1'b1, 1'b1);
        add_row(dhg_pkg::OP_COUNT,  16'd0,     ROW_SILENT, 8'd0, 1'b0, 1'b0);
        add_row(dhg_pkg::OP_COUNT,  16'd16384, ROW_TYPED,  8'd0, 1'b1, 1'b1);
        add_row(dhg_pkg::OP_COUNT,  16'h8000,  ROW_TYPED,  8'd0, 1'b1, 1'b1);
        add_row(dhg_pkg::OP_COUNT,  16'hFFFF,  ROW_TYPED,  8'd0, 1'b1, 1'b1);
        add_row(OP_UNUSED,          16'd1234,  ROW_SILENT, 8'd0, 1'b0, 1'b0);
        // A finish with nothing counted leaves the whole table at zero.
        add_row(dhg_pkg::OP_FINISH, 16'd0,     ROW_SILENT, 8'd0, 1'b0, 1'b0);
        add_row(dhg_pkg::OP_MAP,    16'd1,     ROW_TYPED,  8'd0, 1'b1, 1'b0);
        add_row(dhg_pkg::OP_MAP,    16'd16383, ROW_TYPED,  8'd0, 1'b1, 1'b0);
        // A frame spread over the whole histogram, with an ignored opcode in
        // the middle that must not be counted.
        add_row(dhg_pkg::OP_COUNT,  16'd2,     ROW_SILENT, 8'd0, 1'b0, 1'b0);
        add_row(dhg_pkg::OP_COUNT,  16'd8,     ROW_SILENT, 8'd0, 1'b0, 1'b0);
        add_row(OP_UNUSED,          16'h5555,  ROW_SILENT, 8'd0, 1'b0, 1'b0);
        add_row(dhg_pkg::OP_COUNT,  16'd8,     ROW_SILENT, 8'd0, 1'b0, 1'b0);
        add_row(dhg_pkg::OP_COUNT,  16'd16383, ROW_SILENT, 8'd0, 1'b0, 1'b0);
        add_row(dhg_pkg::OP_FINISH, 16'hFFFF,  ROW_SILENT, 8'd0, 1'b0, 1'b0);
        // Below the first counted bin the level would be 256 and is held at
        // 255; at the last counted bin the running sum reaches n and gives 0.
        add_row(dhg_pkg::OP_MAP,    16'd1,     ROW_TYPED,  8'd255, 1'b1, 1'b0);
        add_row(dhg_pkg::OP_MAP,    16'd2,     ROW_PREDICTED, 8'd0, 1'b0, 1'b0);
        add_row(dhg_pkg::OP_MAP,    16'd8,     ROW_PREDICTED, 8'd0, 1'b0, 1'b0);
        add_row(dhg_pkg::OP_MAP,    16'd9000,  ROW_PREDICTED, 8'd0, 1'b0, 1'b0);
        add_row(dhg_pkg::OP_MAP,    16'd16383, ROW_TYPED,  8'd0, 1'b1, 1'b0);
        // A second finish straight away finds an empty frame again.
        add_row(dhg_pkg::OP_FINISH, 16'd0,     ROW_SILENT, 8'd0, 1'b0, 1'b0);
        add_row(dhg_pkg::OP_MAP,    16'd8,     ROW_TYPED,  8'd0, 1'b1, 1'b0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.opcode, row.depth, row.kind, row.pixel);
        end

        // Random part: whole frames of counts in a narrow random window, a
        // finish, then maps around the window, with noise mixed in. Narrow
        // windows keep most bins off the divider so finish walks stay short.
        target = sent_items + RANDOM_ITEMS;
        while (sent_items < target) begin
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 255);
            lo   = $urandom_range(1, NUM_BINS - 1);
            hi   = (lo + span > NUM_BINS - 1) ? NUM_BINS - 1 : lo + span;
            num_counts = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(10, 90);
            num_maps   = $urandom_range(20, 80);
            for (int i = 0; i < num_counts && sent_items < target; i++) begin
                maybe_noise();
                send_random(dhg_pkg::OP_COUNT, dhg_pkg::DEPTH_W'($urandom_range(lo, hi)));
            end
            if (sent_items < target) begin
                maybe_noise();
                send_random(dhg_pkg::OP_FINISH, dhg_pkg::DEPTH_W'($urandom));
            end
            map_lo = (lo > 2) ? lo - 2 : 0;
            for (int i = 0; i < num_maps && sent_items < target; i++) begin
                maybe_noise();
                if ($urandom_range(0, 3) != 0) begin
                    send_random(dhg_pkg::OP_MAP,
                                dhg_pkg::DEPTH_W'($urandom_range(map_lo, hi + 2)));
                end else begin
                    send_random(dhg_pkg::OP_MAP, dhg_pkg::DEPTH_W'($urandom));
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d items acted on and %0d ignored, over %0d finished frames",
                 acted_items, ignored_items, frames_built);
        $display("checked %0d grey pixels, %0d failures", checked_pixels, fail_count);
        if (fail_count == 0) begin
            $display("depth_histogram_grayscale_unit_test: PASS");
        end else begin
            $display("depth_histogram_grayscale_unit_test: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dhg_pkg.sv
rtl/dhg_ram.sv
rtl/dhg_divider.sv
rtl/depth_histogram_grayscale_unit.sv
rtl/dhg_checker.sv
tb/sv/depth_histogram_grayscale_unit_test.sv
